// ----- design/mtd_pkg.sv -----
// Shared types, constants and the code-to-character table for the Morse
// timing decoder. No dependencies.
package mtd_pkg;

  localparam int SAMPLE_W     = 12;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_IDX_W    = 3;
  localparam int CHAR_W       = 7;
  localparam int SYM_BITS_W   = 5;
  localparam int SYM_CNT_W    = 3;
  localparam int COUNT_BITS_DEF = 16;

  localparam logic [SYM_CNT_W-1:0] MAX_SYMBOLS  = 3'd5;
  localparam logic [SYM_CNT_W-1:0] SYM_OVERLONG = 3'd6;

  localparam logic [SAMPLE_W-1:0]   LEVEL_THRESHOLD_RST = 12'd72;
  localparam logic [CFG_DATA_W-1:0] DOT_LIMIT_RST       = 16'd30;
  localparam logic [CFG_DATA_W-1:0] CHAR_GAP_RST        = 16'd60;
  localparam logic [CFG_DATA_W-1:0] WORD_GAP_RST        = 16'd120;
  localparam logic [CFG_DATA_W-1:0] END_GAP_RST         = 16'd300;

  localparam logic [CHAR_W-1:0] CHAR_SPACE = 7'h20;
  localparam logic [CHAR_W-1:0] CHAR_NONE  = 7'h00;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEVEL_THRESHOLD = 3'd0,
    REG_DOT_LIMIT       = 3'd1,
    REG_CHAR_GAP        = 3'd2,
    REG_WORD_GAP        = 3'd3,
    REG_END_GAP         = 3'd4
  } mtd_reg_idx_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0]   level_threshold;
    logic [CFG_DATA_W-1:0] dot_limit_ticks;
    logic [CFG_DATA_W-1:0] char_gap_ticks;
    logic [CFG_DATA_W-1:0] word_gap_ticks;
    logic [CFG_DATA_W-1:0] end_gap_ticks;
  } mtd_cfg_t;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
  } mtd_result_t;

  // Up to two results produced by one sample, in delivery order.
  typedef struct packed {
    logic [1:0]  count;
    mtd_result_t res0;
    mtd_result_t res1;
  } mtd_push_t;

  // Index is the leading one (code length marker) followed by the code bits,
  // first symbol most significant, dash = 1. Zero means an unknown code.
  function automatic logic [CHAR_W-1:0] decode_char(input logic [5:0] idx);
    logic [CHAR_W-1:0] ch;
    case (idx)
      6'd2:  ch = 7'h45; // E
      6'd3:  ch = 7'h54; // T
      6'd4:  ch = 7'h49; // I
      6'd5:  ch = 7'h41; // A
      6'd6:  ch = 7'h4E; // N
      6'd7:  ch = 7'h4D; // M
      6'd8:  ch = 7'h53; // S
      6'd9:  ch = 7'h55; // U
      6'd10: ch = 7'h52; // R
      6'd11: ch = 7'h57; // W
      6'd12: ch = 7'h44; // D
      6'd13: ch = 7'h4B; // K
      6'd14: ch = 7'h47; // G
      6'd15: ch = 7'h4F; // O
      6'd16: ch = 7'h48; // H
      6'd17: ch = 7'h56; // V
      6'd18: ch = 7'h46; // F
      6'd20: ch = 7'h4C; // L
      6'd22: ch = 7'h50; // P
      6'd23: ch = 7'h4A; // J
      6'd24: ch = 7'h42; // B
      6'd25: ch = 7'h58; // X
      6'd26: ch = 7'h43; // C
      6'd27: ch = 7'h59; // Y
      6'd28: ch = 7'h5A; // Z
      6'd29: ch = 7'h51; // Q
      6'd32: ch = 7'h35; // 5
      6'd33: ch = 7'h34; // 4
      6'd35: ch = 7'h33; // 3
      6'd39: ch = 7'h32; // 2
      6'd47: ch = 7'h31; // 1
      6'd48: ch = 7'h36; // 6
      6'd56: ch = 7'h37; // 7
      6'd60: ch = 7'h38; // 8
      6'd62: ch = 7'h39; // 9
      6'd63: ch = 7'h30; // 0
      default: ch = CHAR_NONE;
    endcase
    return ch;
  endfunction

endpackage

// ----- design/mtd_cfg_regs.sv -----
// Configuration register bank of the Morse timing decoder.
// Depends on mtd_pkg.
module mtd_cfg_regs
  import mtd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output mtd_cfg_t              cfg
);

  mtd_cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (mtd_reg_idx_t'(wr_index))
        REG_LEVEL_THRESHOLD: cfg_nxt.level_threshold = wr_data[SAMPLE_W-1:0];
        REG_DOT_LIMIT:       cfg_nxt.dot_limit_ticks = wr_data;
        REG_CHAR_GAP:        cfg_nxt.char_gap_ticks  = wr_data;
        REG_WORD_GAP:        cfg_nxt.word_gap_ticks  = wr_data;
        REG_END_GAP:         cfg_nxt.end_gap_ticks   = wr_data;
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.level_threshold <= LEVEL_THRESHOLD_RST;
      cfg_r.dot_limit_ticks <= DOT_LIMIT_RST;
      cfg_r.char_gap_ticks  <= CHAR_GAP_RST;
      cfg_r.word_gap_ticks  <= WORD_GAP_RST;
      cfg_r.end_gap_ticks   <= END_GAP_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- design/mtd_step.sv -----
// Input register, decoder state and the single-pass step logic that turns
// one sample into zero, one or two results. Depends on mtd_pkg.
module mtd_step
  import mtd_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
)(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [SAMPLE_W-1:0] in_sample,
  input  mtd_cfg_t            cfg,
  input  logic                room,
  output logic                push_en,
  output mtd_push_t           push
);

  localparam int CMP_W = (COUNT_BITS > CFG_DATA_W) ? COUNT_BITS : CFG_DATA_W;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  logic                  in_valid_r, in_valid_nxt;
  logic [SAMPLE_W-1:0]   sample_r;
  logic                  level_on_r, level_on_nxt;
  logic [COUNT_BITS-1:0] ticks_r, ticks_nxt;
  logic [SYM_BITS_W-1:0] bits_r, bits_nxt;
  logic [SYM_CNT_W-1:0]  cnt_r, cnt_nxt;

  logic              fire, take;
  logic              level;
  logic [COUNT_BITS-1:0] elapsed;
  logic [CMP_W-1:0]  elapsed_x;
  logic [5:0]        code_idx;
  logic [CHAR_W-1:0] flush_ch;
  logic              flush_ok;
  logic              do_flush;

  assign fire     = in_valid_r && room;
  assign in_stall = in_valid_r && !room;
  assign take     = in_valid && !in_stall;
  assign push_en  = fire;

  always_comb begin
    level     = sample_r > cfg.level_threshold;
    elapsed   = (ticks_r == COUNT_MAX) ? ticks_r : ticks_r + 1'b1;
    elapsed_x = CMP_W'(elapsed);
    // A valid code of n symbols sits in the low n bits; the marker sits above.
    code_idx  = (6'd1 << cnt_r) | {1'b0, bits_r};
    flush_ch  = decode_char(code_idx);
    flush_ok  = (cnt_r != '0) && (cnt_r <= MAX_SYMBOLS) && (flush_ch != CHAR_NONE);

    level_on_nxt = level_on_r;
    ticks_nxt    = elapsed;
    bits_nxt     = bits_r;
    cnt_nxt      = cnt_r;
    do_flush     = 1'b0;
    push         = '0;

    if (level != level_on_r) begin
      level_on_nxt = level;
      ticks_nxt    = '0;
      if (level) begin
        if (elapsed_x >= CMP_W'(cfg.word_gap_ticks)) begin
          do_flush = 1'b1;
          if (flush_ok) begin
            push.count = 2'd2;
            push.res0  = '{character: flush_ch, last: 1'b0};
            push.res1  = '{character: CHAR_SPACE, last: 1'b1};
          end else begin
            push.count = 2'd1;
            push.res0  = '{character: CHAR_SPACE, last: 1'b1};
          end
        end else if (elapsed_x >= CMP_W'(cfg.char_gap_ticks)) begin
          do_flush   = 1'b1;
          push.count = {1'b0, flush_ok};
          push.res0  = '{character: flush_ch, last: 1'b1};
        end
      end else begin
        if (cnt_r < MAX_SYMBOLS) begin
          bits_nxt = {bits_r[SYM_BITS_W-2:0],
                      !(elapsed_x < CMP_W'(cfg.dot_limit_ticks))};
          cnt_nxt  = cnt_r + 1'b1;
        end else begin
          cnt_nxt  = SYM_OVERLONG;
        end
      end
    end else if (!level && (elapsed_x >= CMP_W'(cfg.end_gap_ticks))) begin
      ticks_nxt  = '0;
      do_flush   = 1'b1;
      push.count = {1'b0, flush_ok};
      push.res0  = '{character: flush_ch, last: 1'b1};
    end

    if (do_flush) begin
      bits_nxt = '0;
      cnt_nxt  = '0;
    end

    in_valid_nxt = take ? 1'b1 : (fire ? 1'b0 : in_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      level_on_r <= 1'b0;
      ticks_r    <= '0;
      bits_r     <= '0;
      cnt_r      <= '0;
    end else begin
      in_valid_r <= in_valid_nxt;
      if (fire) begin
        level_on_r <= level_on_nxt;
        ticks_r    <= ticks_nxt;
        bits_r     <= bits_nxt;
        cnt_r      <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      sample_r <= in_sample;
    end
  end

endmodule

// ----- design/mtd_out_fifo.sv -----
// Four-entry result queue that takes up to two results per cycle and hands
// out one per cycle while out_stall is low. Depends on mtd_pkg.
module mtd_out_fifo
  import mtd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_en,
  input  mtd_push_t         push,
  output logic              room,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CHAR_W-1:0] out_character,
  output logic              out_last
);

  mtd_result_t entry_r [4];
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [2:0] count_r, count_nxt;
  logic [1:0] push_n;
  logic       pop;

  assign push_n    = push_en ? push.count : 2'd0;
  assign out_valid = count_r != 3'd0;
  assign pop       = out_valid && !out_stall;
  // Two free slots are kept for every sample, whatever it produces.
  assign room      = count_r <= 3'd2;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + push_n;
    rd_ptr_nxt = rd_ptr_r + {1'b0, pop};
    count_nxt  = count_r + {1'b0, push_n} - {2'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      entry_r[wr_ptr_r] <= push.res0;
    end
    if (push_n == 2'd2) begin
      entry_r[wr_ptr_r + 2'd1] <= push.res1;
    end
  end

  assign out_character = entry_r[rd_ptr_r].character;
  assign out_last      = entry_r[rd_ptr_r].last;

endmodule

// ----- design/morse_timing_decoder.sv -----
// Morse timing decoder: one converter sample per request in, decoded ASCII out.
// A sample accepted into the input register is decoded as it leaves, which waits
// for room in the result queue; the queue then offers its first result. Throughput:
// one sample per cycle while the queue has room; one result out per cycle while
// out_stall is low, and a sample that yields a letter and a space takes a turn for each.
// Reset (rst_n low, synchronous) restores register defaults, empties the queue.
//
// Structure: an input register holds the sample; a single combinational pass
// compares it with the threshold, advances the saturating tick counter, and
// updates the pending dot/dash code, decoding it through a constant table when
// a gap closes the character. Results land in a small queue, which also gives
// the skid room so input keeps flowing while results wait on out_stall, till full.
// Depends on mtd_pkg, mtd_cfg_regs, mtd_step and mtd_out_fifo.
module morse_timing_decoder
  import mtd_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
)(
  input  logic                  clk,
  input  logic                  rst_n,
  // Sample requests.
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [SAMPLE_W-1:0]   in_sample,
  // Result requests.
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [CHAR_W-1:0]     out_character,
  output logic                  out_last,
  // Register writes.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  mtd_cfg_t  cfg;
  mtd_push_t push;
  logic      push_en;
  logic      room;

  // Register writes are always taken; indexes past the list are dropped.
  assign cfg_ready = 1'b1;

  mtd_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  mtd_step #(
    .COUNT_BITS (COUNT_BITS)
  ) u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_sample (in_sample),
    .cfg       (cfg),
    .room      (room),
    .push_en   (push_en),
    .push      (push)
  );

  mtd_out_fifo u_fifo (
    .clk           (clk),
    .rst_n         (rst_n),
    .push_en       (push_en),
    .push          (push),
    .room          (room),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_character (out_character),
    .out_last      (out_last)
  );

endmodule

// ----- verif/tb_morse_timing_decoder.sv -----
// Self-checking testbench for morse_timing_decoder: keyed sample streams in,
// decoded characters out, checked against a cycle-free model of the decoder.
// Depends on mtd_pkg and the morse_timing_decoder RTL only.
`timescale 1ns / 1ps

module tb_morse_timing_decoder;
  import mtd_pkg::*;

  localparam int TICK_W       = COUNT_BITS_DEF;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int MAX_REPORTS  = 10;
  localparam byte NO_LETTER   = "*";

  // Letters indexed by a leading length marker followed by the code bits,
  // first symbol most significant and dash = 1. A star marks a code that
  // does not decode to anything.
  string morse_letters =
    "**ETIANMSURWDKGOHVF*L*PJBXCYZQ**54*3***2*******16*******7***8*90";

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  logic [SAMPLE_W-1:0]   in_sample = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [CHAR_W-1:0]     out_character;
  logic                  out_last;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // Model copy of the register file, starting from the reset defaults.
  logic [SAMPLE_W-1:0]   thr_q = LEVEL_THRESHOLD_RST;
  logic [CFG_DATA_W-1:0] dot_q = DOT_LIMIT_RST;
  logic [CFG_DATA_W-1:0] chg_q = CHAR_GAP_RST;
  logic [CFG_DATA_W-1:0] wdg_q = WORD_GAP_RST;
  logic [CFG_DATA_W-1:0] end_q = END_GAP_RST;

  // Model copy of the decoder state.
  logic                  level_on   = 1'b0;
  logic [TICK_W-1:0]     tick_count = '0;
  logic [SYM_BITS_W-1:0] sym_bits   = '0;
  logic [SYM_CNT_W-1:0]  sym_cnt    = '0;

  mtd_result_t expected_chars[$];
  int          mismatch_count = 0;
  int          samples_sent   = 0;
  int          send_idle_pct  = 35;
  int          recv_idle_pct  = 79;

  morse_timing_decoder dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_sample     (in_sample),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_character (out_character),
    .out_last      (out_last),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Safety net: a hung handshake or a missing result ends the run here.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Model of the decoder
  // ---------------------------------------------------------------------------

  function automatic void push_char(input logic [CHAR_W-1:0] c);
    mtd_result_t r;
    r.character = c;
    r.last      = 1'b0;
    expected_chars.push_back(r);
  endfunction

  // Closes the pending code. Only codes of one to five symbols can decode;
  // an empty or over-long code is dropped without a result.
  function automatic void flush_code();
    int  idx;
    byte letter;
    if (sym_cnt >= 1 && sym_cnt <= MAX_SYMBOLS) begin
      idx    = (1 << sym_cnt) + (sym_bits & ((1 << sym_cnt) - 1));
      letter = morse_letters[idx];
      if (letter != NO_LETTER) push_char(letter[CHAR_W-1:0]);
    end
    sym_bits = '0;
    sym_cnt  = '0;
  endfunction

  // Works out the characters that one accepted sample causes and queues them.
  function automatic void predict_sample(input logic [SAMPLE_W-1:0] s);
    logic              level_now;
    logic [TICK_W-1:0] elapsed;
    int                queued;
    mtd_result_t       tail;
    level_now = (s > thr_q);
    elapsed   = (&tick_count) ? tick_count : tick_count + 1'b1;
    queued    = expected_chars.size();
    if (level_now != level_on) begin
      if (level_now) begin
        // The word gap is tested first, so it wins even when it is shorter.
        if (elapsed >= wdg_q) begin
          flush_code();
          push_char(CHAR_SPACE);
        end else if (elapsed >= chg_q) begin
          flush_code();
        end
      end else if (sym_cnt < MAX_SYMBOLS) begin
        sym_bits = {sym_bits[SYM_BITS_W-2:0], elapsed >= dot_q};
        sym_cnt  = sym_cnt + 1'b1;
      end else begin
        sym_cnt = SYM_OVERLONG;
      end
      level_on   = level_now;
      tick_count = '0;
    end else if (!level_now && elapsed >= end_q) begin
      flush_code();
      tick_count = '0;
    end else begin
      tick_count = elapsed;
    end
    if (expected_chars.size() > queued) begin
      tail      = expected_chars.pop_back();
      tail.last = 1'b1;
      expected_chars.push_back(tail);
    end
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] value);
    case (idx)
      REG_LEVEL_THRESHOLD: thr_q = value[SAMPLE_W-1:0];
      REG_DOT_LIMIT:       dot_q = value;
      REG_CHAR_GAP:        chg_q = value;
      REG_WORD_GAP:        wdg_q = value;
      REG_END_GAP:         end_q = value;
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Monitors. Both sample at the rising edge, so they see the values that the
  // DUT saw; the stimulus side only changes inputs through nonblocking writes.
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) predict_sample(in_sample);
    if (rst_n && cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_data);
  end

  always @(posedge clk) begin : check_results
    mtd_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_chars.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result: char 0x%02h last %0b", out_character, out_last);
      end else begin
        want = expected_chars.pop_front();
        if (want.character !== out_character || want.last !== out_last) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("result mismatch: expected char 0x%02h last %0b, got char 0x%02h last %0b",
                     want.character, want.last, out_character, out_last);
        end
      end
    end
  end

  // Receiver back-pressure, with the rate set by the current idling mode.
  always @(posedge clk) out_stall <= ($urandom_range(99) < recv_idle_pct);

  // ---------------------------------------------------------------------------
  // Stimulus primitives
  // ---------------------------------------------------------------------------

  // Offers one sample request and returns at the edge that accepts it. The
  // valid is left high so back-to-back requests need no extra edge; whoever
  // stops sending lowers it (see wait_idle).
  task automatic send_sample(input logic [SAMPLE_W-1:0] s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    do @(posedge clk); while (in_stall);
    samples_sent++;
  endtask

  // A random sample value on the requested side of the current threshold.
  function automatic logic [SAMPLE_W-1:0] level_sample(input bit on);
    if (on) return SAMPLE_W'($urandom_range(4095, thr_q + 1));
    return SAMPLE_W'($urandom_range(thr_q, 0));
  endfunction

  task automatic send_run(input bit on, input int n);
    repeat (n) send_sample(level_sample(on));
  endtask

  // Keys one code, first symbol in the highest used bit. Symbols inside the
  // code are separated by short random gaps; final_gap is the off run after
  // the last symbol, which decides how the code is closed.
  task automatic key_letter(input logic [5:0] code, input int len, input int final_gap);
    int on_len;
    int gap;
    for (int i = len - 1; i >= 0; i--) begin
      on_len = code[i] ? dot_q + $urandom_range(2, 0) : $urandom_range(dot_q - 1, 1);
      gap    = (i == 0) ? final_gap : $urandom_range(chg_q - 1, 1);
      send_run(1'b1, on_len);
      send_run(1'b0, gap);
    end
  endtask

  // Stops sending and waits until every expected character is out, then waits
  // out SETTLE_CYCLES in case the last samples are still inside the pipeline.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Offers one register write request; the valid stays high like the sample
  // channel, and write_regs lowers it after a burst.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic write_regs(input logic [CFG_DATA_W-1:0] thr, input logic [CFG_DATA_W-1:0] dot,
                            input logic [CFG_DATA_W-1:0] chg, input logic [CFG_DATA_W-1:0] wdg,
                            input logic [CFG_DATA_W-1:0] endg);
    cfg_write(REG_LEVEL_THRESHOLD, thr);
    cfg_write(REG_DOT_LIMIT, dot);
    cfg_write(REG_CHAR_GAP, chg);
    cfg_write(REG_WORD_GAP, wdg);
    cfg_write(REG_END_GAP, endg);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Out of reset the defaults apply: 72 is still off and 73 is on, a five
  // tick pulse is a dot, 35 ticks a dash, and the three gap lengths decide
  // between letter, letter plus space, and an idle flush.
  task automatic test_reset_values();
    send_sample(SAMPLE_W'(LEVEL_THRESHOLD_RST));
    send_sample(SAMPLE_W'(LEVEL_THRESHOLD_RST + 1));
    send_run(1'b1, 4);
    send_run(1'b0, 3);
    send_run(1'b1, 35);
    send_run(1'b0, 70);
    send_run(1'b1, 10);
    send_run(1'b0, 130);
    send_run(1'b1, 1);
    send_run(1'b0, 310);
    wait_idle();
  endtask

  // Writes to indexes past the last register must be ignored, and the
  // threshold keeps only its low twelve bits.
  task automatic test_register_writes();
    for (int i = int'(REG_END_GAP) + 1; i < (1 << CFG_IDX_W); i++)
      cfg_write(CFG_IDX_W'(i), '1);
    write_regs(16'hF7FF, 2, 3, 5, 8);
  endtask

  // Sample extremes and the values right at the threshold.
  task automatic test_sample_extremes();
    send_sample('1);
    send_sample('0);
    send_sample(SAMPLE_W'(thr_q + 1));
    send_sample(thr_q);
    send_run(1'b0, end_q + 2);
    wait_idle();
  endtask

  // Idle flushes with nothing pending produce no letter; single pulses are then
  // closed by a word gap, which also produces its space, and by an idle flush.
  task automatic test_empty_flush();
    send_run(1'b0, 3 * end_q);
    send_run(1'b1, 1);
    send_run(1'b0, wdg_q + 1);
    send_run(1'b1, 1);
    send_run(1'b0, end_q + 2);
    wait_idle();
  endtask

  // A letter, the five-dash digit, an unknown code, an over-long code, and
  // all three ways of closing a character.
  task automatic test_letters();
    key_letter(6'b000001, 2, chg_q);
    key_letter(6'b011111, 5, wdg_q);
    key_letter(6'b000011, 4, chg_q);
    key_letter(6'b101010, 6, wdg_q);
    key_letter(6'b000001, 1, chg_q);
    key_letter(6'b000000, 1, end_q + 2);
    wait_idle();
  endtask

  // With the word gap shorter than the character gap, a gap between the two
  // still counts as a word gap.
  task automatic test_gap_order();
    write_regs(2047, 2, 5, 2, 12);
    send_run(1'b1, 1);
    send_run(1'b0, 3);
    send_run(1'b1, 1);
    send_run(1'b0, 1);
    send_run(1'b1, 3);
    send_run(1'b0, 14);
    wait_idle();
  endtask

  // Register extremes: with everything at its minimum every pulse is a dash
  // and every gap closes a word; with the threshold at full scale nothing
  // can ever be on.
  task automatic test_register_extremes();
    write_regs(0, 1, 1, 1, 1);
    send_sample('0);
    send_sample(1);
    send_sample('0);
    send_sample('1);
    send_sample('0);
    send_sample('0);
    send_sample('0);
    send_sample('1);
    send_sample('1);
    send_sample('0);
    wait_idle();
    write_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_sample('1);
    send_sample('0);
    send_sample('1);
    send_sample(12'h800);
    wait_idle();
  endtask

  // A pulse held on far past the end gap: nothing is flushed while the level
  // stays on, and against a large dot limit the long pulse is a dash.
  task automatic test_long_hold();
    write_regs(1000, 100, 2, 3, 4);
    send_run(1'b0, 2);
    send_run(1'b1, 150);
    send_run(1'b0, 8);
    wait_idle();
  endtask

  // Mostly well-formed keying with random codes and gaps under a random
  // timing setup, with bursts of raw noise mixed in.
  task automatic test_random_traffic(input int n_items, input bit hold_off);
    int         first;
    int         len;
    int         gap;
    int         pick;
    int         chg;
    int         wdg;
    logic [5:0] code;
    bit         paused;
    wait_idle();
    chg = $urandom_range(5, 2);
    wdg = chg + $urandom_range(4, 1);
    write_regs(CFG_DATA_W'($urandom_range(4000, 1)), CFG_DATA_W'($urandom_range(4, 2)),
               CFG_DATA_W'(chg), CFG_DATA_W'(wdg),
               CFG_DATA_W'(wdg + $urandom_range(12, 5)));
    first  = samples_sent;
    paused = 1'b0;
    while (samples_sent - first < n_items) begin
      // Once per phase where asked, stop sending until the output has drained.
      if (hold_off && !paused && samples_sent - first >= n_items / 2) begin
        wait_idle();
        paused = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 10) begin
        repeat ($urandom_range(12, 1)) send_sample(SAMPLE_W'($urandom_range(4095)));
      end else begin
        len  = $urandom_range(6, 1);
        code = 6'($urandom_range(63));
        pick = $urandom_range(99);
        if (pick < 50)
          gap = $urandom_range(wdg_q - 1, chg_q);
        else if (pick < 85)
          gap = $urandom_range(wdg_q + 2, wdg_q);
        else
          gap = $urandom_range(end_q + 4, end_q + 1);
        key_letter(code, len, gap);
      end
    end
    wait_idle();
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Sender idles often, receiver stalls most of the time.
    test_reset_values();
    test_register_writes();
    test_sample_extremes();
    test_empty_flush();
    test_letters();
    test_gap_order();
    test_register_extremes();
    test_long_hold();
    test_random_traffic(250, 1'b1);

    // The other way round.
    send_idle_pct = 79;
    recv_idle_pct = 35;
    test_random_traffic(250, 1'b0);

    // Full rate on both sides.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(200, 1'b0);

    wait_idle();
    if (mismatch_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
